// ===== rtl/core/lwma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LWMA retarget package
// Shared widths, payload types and the compact-target decoder.
// ----------------------------------------------------------------------------
package lwma_pkg;

    localparam int WINDOW = 64;
    localparam int TIDX_W = $clog2(WINDOW + 1);
    localparam int BIDX_W = $clog2(WINDOW);
    localparam int J_W    = $clog2(WINDOW + 1);
    localparam int K_W    = 16 + $clog2(WINDOW + 2) - 1;
    localparam int NK_W   = K_W + J_W;
    localparam int DV_W   = K_W + 2 * J_W;
    localparam int ST_W   = 34;
    localparam int WP_W   = ST_W + J_W + 1;
    localparam int TS_W   = WP_W + J_W;
    localparam int P_W    = 256 + TS_W;
    localparam int MC_W   = $clog2(TS_W);

    localparam logic [1:0] CFG_SPACING   = 2'd0;
    localparam logic [1:0] CFG_LIMIT     = 2'd1;
    localparam logic [1:0] CFG_MIN_DIFF  = 2'd2;
    localparam logic [1:0] CFG_NO_RETGT  = 2'd3;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef struct packed {
        logic        op;
        logic [31:0] block_time;
        logic [31:0] block_bits;
    } in_t;

    typedef struct packed {
        logic [31:0] next_bits;
        logic        window_full;
    } out_t;

    typedef struct packed {
        op_t         kind;
        logic [31:0] block_time;
        logic [31:0] block_bits;
    } cmd_t;

    typedef struct packed {
        logic [15:0] target_spacing;
        logic [31:0] limit_bits;
        logic        allow_min_difficulty;
        logic        no_retarget;
    } cfg_t;

    function automatic logic [255:0] decode_compact(input logic [31:0] c);
        logic [7:0]   size;
        logic [255:0] word;
        logic [7:0]   sh;
        size = c[31:24];
        word = {233'd0, c[22:0]};
        sh   = 8'((size - 8'd3) << 3);
        if (size <= 8'd3) begin
            return word >> {(8'd3 - size), 3'b000};
        end else if (size > 8'd34) begin
            return '0;
        end else begin
            return word << sh;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lwma_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LWMA front end
// Accepts input transfers, tags them as append or query, and holds them in
// a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module lwma_front import lwma_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      q_valid,
    input  wire logic q_ready,
    output cmd_t      q_cmd
);

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;
    cmd_t       cmd_in;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        cmd_in.kind       = s_data.op ? OP_QUERY : OP_APPEND;
        cmd_in.block_time = s_data.block_time;
        cmd_in.block_bits = s_data.block_bits;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lwma_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LWMA engine
// Owns the timestamp and target rings, walks the window with a serial
// divider and shift-add multiplier, and encodes the compact answer.
// ----------------------------------------------------------------------------
module lwma_engine import lwma_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire cmd_t q_cmd,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_LAT1  = 15'b000000000000010,
        ST_LAT2  = 15'b000000000000100,
        ST_SETUP = 15'b000000000001000,
        ST_FDIV  = 15'b000000000010000,
        ST_PRIME = 15'b000000000100000,
        ST_WAITR = 15'b000000001000000,
        ST_ENT   = 15'b000000010000000,
        ST_MAC   = 15'b000000100000000,
        ST_EDIV  = 15'b000001000000000,
        ST_TFLR  = 15'b000010000000000,
        ST_MULT  = 15'b000100000000000,
        ST_CHK   = 15'b001000000000000,
        ST_ENC   = 15'b010000000000000,
        ST_DONE  = 15'b100000000000000
    } state_t;

    state_t              state_reg;
    logic [31:0]         time_mem [WINDOW + 1];
    logic [31:0]         bits_mem [WINDOW];
    logic [TIDX_W-1:0]   thead_reg;
    logic [BIDX_W-1:0]   bhead_reg;
    logic [31:0]         height_reg;
    logic [TIDX_W-1:0]   ta_reg;
    logic [BIDX_W-1:0]   ba_reg;
    logic [31:0]         tq_reg;
    logic [31:0]         bq_reg;
    logic [31:0]         cand_reg;
    logic [15:0]         teff_reg;
    logic [255:0]        limit_reg;
    logic [K_W-1:0]      k_reg;
    logic [DV_W-1:0]     dvs_reg;
    logic [DV_W-1:0]     dsr_reg;
    logic [DV_W-1:0]     rem_reg;
    logic [255:0]        dvd_reg;
    logic [7:0]          cnt_reg;
    logic [NK_W-1:0]     floor_reg;
    logic [31:0]         prev_reg;
    logic [J_W-1:0]      j_reg;
    logic signed [ST_W-1:0] st_reg;
    logic signed [WP_W-1:0] wp_reg;
    logic signed [TS_W-1:0] tsum_reg;
    logic [TS_W-1:0]     tf_reg;
    logic [255:0]        sum_reg;
    logic [P_W-1:0]      p_reg;
    logic [MC_W-1:0]     mc_reg;
    logic [255:0]        ey_reg;
    logic [5:0]          esize_reg;
    logic [31:0]         res_reg;
    logic                m_valid_reg;
    out_t                m_data_reg;

    logic [DV_W:0]          rem_sh;
    logic                   ge;
    logic [DV_W-1:0]        rem_next;
    logic [255:0]           dvd_next;
    logic [K_W:0]           kp;
    logic signed [ST_W-1:0] st_raw;
    logic signed [ST_W-1:0] cap6;
    logic [32:0]            late_lim;
    logic [TIDX_W-1:0]      ta_inc;
    logic [BIDX_W-1:0]      ba_inc;
    logic [23:0]            mant;
    logic                   is_append;
    logic [NK_W-1:0]        nk;
    logic [NK_W+31:0]       nk_rcp;

    assign q_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign is_append = (q_cmd.kind == OP_APPEND);

    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[255]};
        ge       = (rem_sh >= {1'b0, dsr_reg});
        rem_next = ge ? DV_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[DV_W-1:0];
        dvd_next = {dvd_reg[254:0], ge};
        kp       = (K_W + 1)'((WINDOW + 1) * teff_reg);
        st_raw   = $signed({2'b00, tq_reg}) - $signed({2'b00, prev_reg});
        cap6     = $signed(ST_W'(6 * teff_reg));
        late_lim = {1'b0, tq_reg} + 33'(10 * teff_reg);
        ta_inc   = (ta_reg == TIDX_W'(WINDOW)) ? '0 : ta_reg + 1'b1;
        ba_inc   = (ba_reg == BIDX_W'(WINDOW - 1)) ? '0 : ba_reg + 1'b1;
        mant     = ey_reg[255:232];
        nk       = NK_W'(k_reg) * NK_W'(WINDOW);
        nk_rcp   = (NK_W + 32)'(nk) * (NK_W + 32)'(32'hCCCC_CCCD);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid && is_append) begin
            time_mem[thead_reg] <= q_cmd.block_time;
            bits_mem[bhead_reg] <= q_cmd.block_bits;
        end
        tq_reg <= time_mem[ta_reg];
        bq_reg <= bits_mem[ba_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thead_reg   <= '0;
            bhead_reg   <= '0;
            height_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        if (is_append) begin
                            thead_reg <= (thead_reg == TIDX_W'(WINDOW)) ? '0 : thead_reg + 1'b1;
                            bhead_reg <= (bhead_reg == BIDX_W'(WINDOW - 1)) ? '0
                                                                             : bhead_reg + 1'b1;
                            if (height_reg != 32'hFFFF_FFFF) begin
                                height_reg <= height_reg + 32'd1;
                            end
                            res_reg   <= '0;
                            state_reg <= ST_DONE;
                        end else begin
                            ta_reg    <= (thead_reg == '0) ? TIDX_W'(WINDOW) : thead_reg - 1'b1;
                            ba_reg    <= (bhead_reg == '0) ? BIDX_W'(WINDOW - 1)
                                                           : bhead_reg - 1'b1;
                            cand_reg  <= q_cmd.block_time;
                            teff_reg  <= (cfg.target_spacing == '0) ? 16'd1 : cfg.target_spacing;
                            limit_reg <= decode_compact(cfg.limit_bits);
                            state_reg <= ST_LAT1;
                        end
                    end
                end
                ST_LAT1: begin
                    state_reg <= ST_LAT2;
                end
                ST_LAT2: begin
                    ey_reg    <= limit_reg;
                    esize_reg <= 6'd32;
                    if (height_reg == '0) begin
                        state_reg <= ST_ENC;
                    end else if (cfg.no_retarget) begin
                        res_reg   <= bq_reg;
                        state_reg <= ST_DONE;
                    end else if (cfg.allow_min_difficulty && ({1'b0, cand_reg} > late_lim)) begin
                        state_reg <= ST_ENC;
                    end else if (height_reg < 32'(WINDOW + 1)) begin
                        state_reg <= ST_ENC;
                    end else begin
                        k_reg     <= kp[K_W:1];
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    dvs_reg   <= DV_W'(k_reg) * DV_W'(WINDOW * WINDOW);
                    ta_reg    <= thead_reg;
                    ba_reg    <= bhead_reg;
                    state_reg <= ST_FDIV;
                end
                ST_FDIV: begin
                    floor_reg <= NK_W'(nk_rcp >> 35);
                    state_reg <= ST_PRIME;
                end
                ST_PRIME: begin
                    prev_reg  <= tq_reg;
                    ta_reg    <= ta_inc;
                    j_reg     <= J_W'(1);
                    sum_reg   <= '0;
                    tsum_reg  <= '0;
                    state_reg <= ST_WAITR;
                end
                ST_WAITR: begin
                    state_reg <= ST_ENT;
                end
                ST_ENT: begin
                    st_reg    <= (st_raw > cap6) ? cap6 : st_raw;
                    prev_reg  <= tq_reg;
                    ta_reg    <= ta_inc;
                    ba_reg    <= ba_inc;
                    dvd_reg   <= decode_compact(bq_reg);
                    dsr_reg   <= dvs_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    wp_reg    <= $signed(WP_W'(st_reg)) * $signed(WP_W'({1'b0, j_reg}));
                    state_reg <= ST_EDIV;
                end
                ST_EDIV: begin
                    rem_reg <= rem_next;
                    dvd_reg <= dvd_next;
                    cnt_reg <= cnt_reg + 8'd1;
                    if (cnt_reg == 8'd255) begin
                        sum_reg  <= sum_reg + dvd_next;
                        tsum_reg <= tsum_reg + {{(TS_W - WP_W){wp_reg[WP_W-1]}}, wp_reg};
                        if (j_reg == J_W'(WINDOW)) begin
                            state_reg <= ST_TFLR;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_ENT;
                        end
                    end
                end
                ST_TFLR: begin
                    if (tsum_reg < $signed({{(TS_W - NK_W){1'b0}}, floor_reg})) begin
                        tf_reg <= {{(TS_W - NK_W){1'b0}}, floor_reg};
                    end else begin
                        tf_reg <= tsum_reg;
                    end
                    p_reg     <= '0;
                    mc_reg    <= MC_W'(TS_W - 1);
                    state_reg <= ST_MULT;
                end
                ST_MULT: begin
                    p_reg <= {p_reg[P_W-2:0], 1'b0}
                             + (tf_reg[mc_reg] ? {{TS_W{1'b0}}, sum_reg} : '0);
                    if (mc_reg == '0) begin
                        state_reg <= ST_CHK;
                    end else begin
                        mc_reg <= mc_reg - 1'b1;
                    end
                end
                ST_CHK: begin
                    if ((|p_reg[P_W-1:256]) || (p_reg[255:0] > limit_reg)) begin
                        ey_reg <= limit_reg;
                    end else begin
                        ey_reg <= p_reg[255:0];
                    end
                    esize_reg <= 6'd32;
                    state_reg <= ST_ENC;
                end
                ST_ENC: begin
                    if (esize_reg != '0 && ey_reg[255:248] == 8'd0) begin
                        ey_reg    <= {ey_reg[247:0], 8'd0};
                        esize_reg <= esize_reg - 6'd1;
                    end else begin
                        if (mant[23]) begin
                            res_reg <= {2'b00, esize_reg + 6'd1, 8'd0, mant[23:8]};
                        end else begin
                            res_reg <= {2'b00, esize_reg, mant};
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.next_bits   <= res_reg;
                        m_data_reg.window_full <= (height_reg >= 32'(WINDOW + 1));
                        state_reg              <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lwma_difficulty_retarget_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LWMA difficulty retarget top
// Append: the result is returned without a window walk. Query: early answers
// skip the walk; a full window walk runs the serial divider once per window
// entry, for all 64 entries.
// One item is processed at a time.
// Reset: synchronous active-low aresetn empties the rings and queue and
// restores the configuration defaults.
// ----------------------------------------------------------------------------
module lwma_difficulty_retarget_top import lwma_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_spacing       <= 16'd120;
            cfg_reg.limit_bits           <= 32'h1D00_FFFF;
            cfg_reg.allow_min_difficulty <= 1'b0;
            cfg_reg.no_retarget          <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SPACING:  cfg_reg.target_spacing       <= cfg_wdata[15:0];
                CFG_LIMIT:    cfg_reg.limit_bits           <= cfg_wdata;
                CFG_MIN_DIFF: cfg_reg.allow_min_difficulty <= cfg_wdata[0];
                CFG_NO_RETGT: cfg_reg.no_retarget          <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    lwma_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    lwma_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ===== tb/sv/lwma_difficulty_retarget_top_tb.sv =====
// ----------------------------------------------------------------------------
// LWMA difficulty retarget testbench
// Drives appends and queries through the valid/ready channels and rewrites
// the configuration between phases. A scoreboard replays the weighted
// solvetime average on its own copy of the window and compares every
// result, field by field, with its prediction.
// ----------------------------------------------------------------------------
module lwma_difficulty_retarget_top_tb;
    import lwma_pkg::*;

    localparam int STALL_LIMIT = 200000;

    class retarget_scoreboard;
        logic [31:0] time_ring [0:64];
        logic [31:0] bits_ring [0:63];
        int          time_head;
        int          bits_head;
        logic [31:0] height;
        logic [15:0] spacing;
        logic [31:0] limit_bits;
        logic        min_diff;
        logic        hold_bits;
        out_t        pending_results[$];
        int          failures;

        function new();
            for (int i = 0; i < 65; i++) time_ring[i] = '0;
            for (int i = 0; i < 64; i++) bits_ring[i] = '0;
            time_head  = 0;
            bits_head  = 0;
            height     = '0;
            spacing    = 16'd120;
            limit_bits = 32'h1D00FFFF;
            min_diff   = 1'b0;
            hold_bits  = 1'b0;
            failures   = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] data);
            case (index)
                CFG_SPACING:  spacing    = data[15:0];
                CFG_LIMIT:    limit_bits = data;
                CFG_MIN_DIFF: min_diff   = data[0];
                CFG_NO_RETGT: hold_bits  = data[0];
                default: ;
            endcase
        endfunction

        function logic [255:0] unpack_target(logic [31:0] c);
            int           sz;
            logic [255:0] v;
            sz = c[31:24];
            v  = {233'd0, c[22:0]};
            if (sz <= 3) return v >> (8 * (3 - sz));
            return v << (8 * (sz - 3));
        endfunction

        function logic [31:0] pack_target(logic [255:0] x);
            int           nbits;
            int           sz;
            logic [31:0]  c;
            logic [255:0] shifted;
            nbits = 0;
            for (int i = 255; i >= 0; i--) begin
                if (x[i]) begin
                    nbits = i + 1;
                    break;
                end
            end
            sz = (nbits + 7) / 8;
            if (sz <= 3) begin
                c = x[31:0] << (8 * (3 - sz));
            end else begin
                shifted = x >> (8 * (sz - 3));
                c = shifted[31:0];
            end
            c = {8'd0, c[23:0]};
            if (c[23]) begin
                c = c >> 8;
                sz++;
            end
            return c | (32'(sz) << 24);
        endfunction

        function longint time_at(int age);
            longint v;
            v = {32'd0, time_ring[(time_head + 129 - age) % 65]};
            return v;
        endfunction

        function logic [31:0] bits_at(int age);
            return bits_ring[(bits_head + 127 - age) % 64];
        endfunction

        function logic [31:0] predict_bits(logic [31:0] cand);
            longint       T, k, floor_t, t, st, cand_l;
            logic [63:0]  dv;
            logic [255:0] lim, total;
            logic [319:0] prod;
            T       = (spacing != 0) ? longint'({48'd0, spacing}) : 1;
            k       = (65 * T) / 2;
            floor_t = 64 * k / 10;
            dv      = k * 4096;
            cand_l  = {32'd0, cand};
            lim     = unpack_target(limit_bits);
            if (height == 0) return pack_target(lim);
            if (hold_bits) return bits_at(0);
            if (min_diff && cand_l > time_at(0) + 10 * T) return pack_target(lim);
            if (height < 65) return pack_target(lim);
            t     = 0;
            total = '0;
            for (int j = 1; j <= 64; j++) begin
                st = time_at(64 - j) - time_at(65 - j);
                if (st > 6 * T) st = 6 * T;
                t += st * j;
                total += unpack_target(bits_at(64 - j)) / {192'd0, dv};
            end
            if (t < floor_t) t = floor_t;
            if (t < 0) t = 0;
            prod = {64'd0, total} * {256'd0, 64'(t)};
            if (prod[319:256] != 0) return pack_target(lim);
            if (prod[255:0] > lim) return pack_target(lim);
            return pack_target(prod[255:0]);
        endfunction

        function void note_transfer(in_t x);
            out_t r;
            if (x.op == OP_APPEND) begin
                time_ring[time_head] = x.block_time;
                time_head = (time_head + 1) % 65;
                bits_ring[bits_head] = x.block_bits;
                bits_head = (bits_head + 1) % 64;
                if (height != 32'hFFFFFFFF) height++;
                r.next_bits = '0;
            end else begin
                r.next_bits = predict_bits(x.block_time);
            end
            r.window_full = (height >= 65);
            pending_results.push_back(r);
        endfunction

        function void check_result(out_t y);
            out_t e;
            if (pending_results.size() == 0) begin
                $error("result with no expectation: next_bits %h", y.next_bits);
                failures++;
                return;
            end
            e = pending_results.pop_front();
            if (y.next_bits !== e.next_bits) begin
                $error("next_bits expected %h actual %h", e.next_bits, y.next_bits);
                failures++;
            end
            if (y.window_full !== e.window_full) begin
                $error("window_full expected %b actual %b", e.window_full, y.window_full);
                failures++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    retarget_scoreboard sb = new();
    logic        no_idle;
    int          stall_cycles;
    logic [31:0] last_time;

    lwma_difficulty_retarget_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_transfer(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    function int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic send_item(logic op, logic [31:0] btime, logic [31:0] bbits);
        int   gap;
        in_t  x;
        gap = draw_gap();
        x.op = op;
        x.block_time = btime;
        x.block_bits = bbits;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_APPEND) last_time = btime;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(index, data);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic [15:0] T, logic [31:0] lim, logic md, logic nr);
        drain();
        write_reg(CFG_SPACING, {16'd0, T});
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_MIN_DIFF, {31'd0, md});
        write_reg(CFG_NO_RETGT, {31'd0, nr});
    endtask

    function logic [31:0] plausible_bits();
        return {8'($urandom_range(8'h18, 8'h1D)), 1'b0, 23'($urandom)};
    endfunction

    task automatic random_items(int count);
        int          T;
        int          roll;
        logic [31:0] t;
        T = (sb.spacing != 0) ? sb.spacing : 1;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                send_item(1'($urandom), $urandom, $urandom);
            end else if (roll < 35) begin
                t = last_time + 32'($urandom_range(0, 12 * T));
                send_item(OP_QUERY, t, $urandom);
            end else begin
                if ($urandom_range(0, 9) == 0)
                    t = last_time - 32'($urandom_range(0, 50 * T));
                else
                    t = last_time + 32'($urandom_range(0, 8 * T));
                send_item(OP_APPEND, t, ($urandom_range(0, 9) == 0) ? $urandom
                                                                   : plausible_bits());
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SPACING;
        cfg_wdata = '0;
        no_idle = 1'b0;
        stall_cycles = 0;
        last_time = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty chain answers the limit in every mode
        send_item(OP_QUERY, 32'd1000, 32'hFFFFFFFF);
        configure(16'd120, 32'h1D00FFFF, 1'b1, 1'b1);
        send_item(OP_QUERY, 32'hFFFFFFFF, 32'd0);
        configure(16'd120, 32'h1D00FFFF, 1'b1, 1'b0);
        send_item(OP_APPEND, 32'd0, 32'd0);
        send_item(OP_APPEND, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_item(OP_QUERY, 32'd0, 32'd0);
        send_item(OP_APPEND, 32'd100, 32'h1D00FFFF);
        send_item(OP_QUERY, 32'd1301, 32'd0);
        send_item(OP_QUERY, 32'd1300, 32'd0);
        configure(16'd120, 32'h1D00FFFF, 1'b0, 1'b1);
        send_item(OP_QUERY, 32'd200, 32'd0);
        configure(16'd120, 32'h1D00FFFF, 1'b0, 1'b0);
        send_item(OP_QUERY, 32'd200, 32'd0);
        send_item(OP_APPEND, 32'd220, 32'h03123456);
        send_item(OP_APPEND, 32'd340, 32'h02123456);
        send_item(OP_APPEND, 32'd460, 32'h00FFFFFF);
        send_item(OP_APPEND, 32'd580, 32'h04923456);
        send_item(OP_APPEND, 32'd700, 32'h22FFFFFF);
        send_item(OP_APPEND, 32'd820, 32'hFF7FFFFF);
        send_item(OP_QUERY, 32'd940, 32'd0);

        random_items(30);
        configure(16'd1, 32'h2100FFFF, 1'b0, 1'b0);
        no_idle = 1'b1;
        random_items(20);
        no_idle = 1'b0;
        configure(16'd65535, 32'hFFFFFFFF, 1'b1, 1'b0);
        random_items(15);
        configure(16'd0, 32'h207FFFFF, 1'b1, 1'b0);
        random_items(15);
        configure(16'd600, 32'd0, 1'b0, 1'b0);
        random_items(10);
        configure(16'd120, 32'h1D00FFFF, 1'b0, 1'b1);
        random_items(10);
        drain();

        if (sb.failures == 0 && sb.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

endmodule

// ===== files.f =====
rtl/core/lwma_pkg.sv
rtl/core/lwma_front.sv
rtl/core/lwma_engine.sv
rtl/core/lwma_difficulty_retarget_top.sv
tb/sv/lwma_difficulty_retarget_top_tb.sv
